@@ rtl/gbe_pkg.sv @@
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants of the gamma bit-plane encoder.
// ----------------------------------------------------------------------------
package gbe_pkg;

  // field widths fixed by the item format
  localparam int unsigned SampleW     = 8;
  localparam int unsigned ColW        = 6;
  localparam int unsigned RowW        = 4;
  localparam int unsigned PlaneOutW   = 3;
  localparam int unsigned ChanW       = 2;
  localparam int unsigned SampleCount = 6;

  // gamma tables: one entry per raw intensity
  localparam int unsigned TableDepth  = 256;

  // parameter defaults
  localparam int unsigned PlanesDef      = 8;
  localparam int unsigned ColumnCountDef = 64;
  localparam int unsigned ScanRowsDef    = 16;

  // request kinds
  localparam logic ReqGamma = 1'b0;
  localparam logic ReqPixel = 1'b1;

  // gamma table select
  localparam logic [ChanW-1:0] ChanRed   = 2'd0;
  localparam logic [ChanW-1:0] ChanGreen = 2'd1;
  localparam logic [ChanW-1:0] ChanBlue  = 2'd2;

  // mapped pixel pair waiting in the lookup stage
  typedef struct packed {
    logic                                 valid;
    logic                                 bank;
    logic [RowW-1:0]                      row;
    logic [ColW-1:0]                      col;
    logic [SampleCount-1:0][SampleW-1:0]  mapped;
  } lookup_t;

endpackage

@@ rtl/gbe_ram.sv @@
// ----------------------------------------------------------------------------
// gbe_ram
// Generic RAM, one write port and two read ports, registered read.
// ----------------------------------------------------------------------------
module gbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

@@ rtl/gbe_lookup.sv @@
// ----------------------------------------------------------------------------
// gbe_lookup
// Input side: gamma table writes, table reads for pixel pairs, frame bank.
// ----------------------------------------------------------------------------
module gbe_lookup #(
  parameter int unsigned COLUMN_COUNT = gbe_pkg::ColumnCountDef,
  parameter int unsigned SCAN_ROWS    = gbe_pkg::ScanRowsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [gbe_pkg::ChanW-1:0]     table_channel_i,
  input  logic [gbe_pkg::SampleW-1:0]   table_index_i,
  input  logic [gbe_pkg::SampleW-1:0]   table_value_i,
  input  logic [gbe_pkg::ColW-1:0]      column_i,
  input  logic [gbe_pkg::RowW-1:0]      scan_row_i,
  input  logic [gbe_pkg::SampleW-1:0]   red_top_i,
  input  logic [gbe_pkg::SampleW-1:0]   green_top_i,
  input  logic [gbe_pkg::SampleW-1:0]   blue_top_i,
  input  logic [gbe_pkg::SampleW-1:0]   red_bottom_i,
  input  logic [gbe_pkg::SampleW-1:0]   green_bottom_i,
  input  logic [gbe_pkg::SampleW-1:0]   blue_bottom_i,
  input  logic                          take_i,
  output gbe_pkg::lookup_t              lk_o
);

  logic                        accept;
  logic                        pix_acc;
  logic                        wr_acc;
  logic                        frame_end;
  logic                        s1_valid_q, s1_valid_d;
  logic                        s1_bank_q;
  logic [gbe_pkg::RowW-1:0]    s1_row_q;
  logic [gbe_pkg::ColW-1:0]    s1_col_q;
  logic                        bank_q, bank_d;
  logic [gbe_pkg::SampleW-1:0] red_t, red_b, grn_t, grn_b, blu_t, blu_b;

  // a held pixel keeps its read data since reads only fire on a new pixel
  assign in_stall_o = s1_valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign pix_acc    = accept && (req_type_i == gbe_pkg::ReqPixel);
  assign wr_acc     = accept && (req_type_i == gbe_pkg::ReqGamma);

  assign frame_end = (9'(column_i) == 9'(COLUMN_COUNT - 1)) &&
                     (7'(scan_row_i) == 7'(SCAN_ROWS - 1));

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pix_acc) begin
      s1_valid_d = 1'b1;
    end else if (take_i) begin
      s1_valid_d = 1'b0;
    end
    bank_d = bank_q;
    if (pix_acc && frame_end) begin
      bank_d = ~bank_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      bank_q     <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      bank_q     <= bank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_bank_q <= bank_q;
      s1_row_q  <= scan_row_i;
      s1_col_q  <= column_i;
    end
  end

  gbe_ram #(
    .WIDTH (gbe_pkg::SampleW),
    .DEPTH (gbe_pkg::TableDepth)
  ) u_red_ram (
    .clk_i     (clk_i),
    .we_i      (wr_acc && (table_channel_i == gbe_pkg::ChanRed)),
    .waddr_i   (table_index_i),
    .wdata_i   (table_value_i),
    .re_i      (pix_acc),
    .raddr_a_i (red_top_i),
    .raddr_b_i (red_bottom_i),
    .rdata_a_o (red_t),
    .rdata_b_o (red_b)
  );

  gbe_ram #(
    .WIDTH (gbe_pkg::SampleW),
    .DEPTH (gbe_pkg::TableDepth)
  ) u_green_ram (
    .clk_i     (clk_i),
    .we_i      (wr_acc && (table_channel_i == gbe_pkg::ChanGreen)),
    .waddr_i   (table_index_i),
    .wdata_i   (table_value_i),
    .re_i      (pix_acc),
    .raddr_a_i (green_top_i),
    .raddr_b_i (green_bottom_i),
    .rdata_a_o (grn_t),
    .rdata_b_o (grn_b)
  );

  gbe_ram #(
    .WIDTH (gbe_pkg::SampleW),
    .DEPTH (gbe_pkg::TableDepth)
  ) u_blue_ram (
    .clk_i     (clk_i),
    .we_i      (wr_acc && (table_channel_i == gbe_pkg::ChanBlue)),
    .waddr_i   (table_index_i),
    .wdata_i   (table_value_i),
    .re_i      (pix_acc),
    .raddr_a_i (blue_top_i),
    .raddr_b_i (blue_bottom_i),
    .rdata_a_o (blu_t),
    .rdata_b_o (blu_b)
  );

  always_comb begin
    lk_o.valid     = s1_valid_q;
    lk_o.bank      = s1_bank_q;
    lk_o.row       = s1_row_q;
    lk_o.col       = s1_col_q;
    lk_o.mapped[0] = red_t;
    lk_o.mapped[1] = grn_t;
    lk_o.mapped[2] = blu_t;
    lk_o.mapped[3] = red_b;
    lk_o.mapped[4] = grn_b;
    lk_o.mapped[5] = blu_b;
  end

endmodule

@@ rtl/gbe_emit.sv @@
// ----------------------------------------------------------------------------
// gbe_emit
// Plane sequencer and output register: one plane byte per beat.
// ----------------------------------------------------------------------------
module gbe_emit #(
  parameter int unsigned PLANES = gbe_pkg::PlanesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbe_pkg::lookup_t              lk_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_bank_o,
  output logic [gbe_pkg::RowW-1:0]      out_row_o,
  output logic [gbe_pkg::PlaneOutW-1:0] out_plane_o,
  output logic [gbe_pkg::ColW-1:0]      out_column_o,
  output logic [gbe_pkg::SampleCount-1:0] plane_byte_o,
  output logic                          last_plane_o
);

  localparam int unsigned PlaneW = (PLANES > 1) ? $clog2(PLANES) : 1;

  logic                                         busy_q;
  logic [PlaneW-1:0]                            plane_q;
  logic [gbe_pkg::SampleCount-1:0][gbe_pkg::SampleW-1:0] m_q;
  logic                                         bank_q;
  logic [gbe_pkg::RowW-1:0]                     row_q;
  logic [gbe_pkg::ColW-1:0]                     col_q;
  logic                                         out_valid_q;
  logic                                         out_load;
  logic                                         last;
  logic [gbe_pkg::PlaneOutW-1:0]                pos;
  logic [gbe_pkg::SampleCount-1:0]              byte_d;

  assign out_load = busy_q && (!out_valid_q || !out_stall_i);
  assign last     = (plane_q == PlaneW'(PLANES - 1));
  assign take_o   = lk_i.valid && (!busy_q || (out_load && last));

  // plane p carries sample bit 8-PLANES+p
  assign pos = gbe_pkg::PlaneOutW'(8 - PLANES) + gbe_pkg::PlaneOutW'(plane_q);

  always_comb begin
    for (int k = 0; k < gbe_pkg::SampleCount; k++) begin
      byte_d[k] = m_q[k][pos];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      plane_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        busy_q  <= 1'b1;
        plane_q <= '0;
      end else if (out_load && last) begin
        busy_q  <= 1'b0;
      end else if (out_load) begin
        plane_q <= plane_q + PlaneW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      m_q    <= lk_i.mapped;
      bank_q <= lk_i.bank;
      row_q  <= lk_i.row;
      col_q  <= lk_i.col;
    end
    if (out_load) begin
      out_bank_o   <= bank_q;
      out_row_o    <= row_q;
      out_plane_o  <= gbe_pkg::PlaneOutW'(plane_q);
      out_column_o <= col_q;
      plane_byte_o <= byte_d;
      last_plane_o <= last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/gamma_bitplane_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// gamma_bitplane_encoder_unit
// Gamma-mapped bit-plane encoder for a half-scan RGB LED matrix.
// ----------------------------------------------------------------------------
// A gamma beat writes one entry of the red, green or blue table (channel
// code 3 writes none) and yields no output. A pixel beat reads both its
// samples from each table at once (two read ports per table RAM), then yields
// PLANES plane bytes, one per cycle unless the output stalls; the next pixel
// pair can wait in the lookup stage meanwhile. Table entries must be
// written before a pixel reads them; the tables are not cleared at reset.
// The frame bank flips after the pixel at the last column and last scan row.
module gamma_bitplane_encoder_unit #(
  parameter int unsigned PLANES       = gbe_pkg::PlanesDef,
  parameter int unsigned COLUMN_COUNT = gbe_pkg::ColumnCountDef,
  parameter int unsigned SCAN_ROWS    = gbe_pkg::ScanRowsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [gbe_pkg::ChanW-1:0]       table_channel_i,
  input  logic [gbe_pkg::SampleW-1:0]     table_index_i,
  input  logic [gbe_pkg::SampleW-1:0]     table_value_i,
  input  logic [gbe_pkg::ColW-1:0]        column_i,
  input  logic [gbe_pkg::RowW-1:0]        scan_row_i,
  input  logic [gbe_pkg::SampleW-1:0]     red_top_i,
  input  logic [gbe_pkg::SampleW-1:0]     green_top_i,
  input  logic [gbe_pkg::SampleW-1:0]     blue_top_i,
  input  logic [gbe_pkg::SampleW-1:0]     red_bottom_i,
  input  logic [gbe_pkg::SampleW-1:0]     green_bottom_i,
  input  logic [gbe_pkg::SampleW-1:0]     blue_bottom_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            out_bank_o,
  output logic [gbe_pkg::RowW-1:0]        out_row_o,
  output logic [gbe_pkg::PlaneOutW-1:0]   out_plane_o,
  output logic [gbe_pkg::ColW-1:0]        out_column_o,
  output logic [gbe_pkg::SampleCount-1:0] plane_byte_o,
  output logic                            last_plane_o
);

  gbe_pkg::lookup_t lk;
  logic             take;

  gbe_lookup #(
    .COLUMN_COUNT (COLUMN_COUNT),
    .SCAN_ROWS    (SCAN_ROWS)
  ) u_lookup (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .table_channel_i (table_channel_i),
    .table_index_i   (table_index_i),
    .table_value_i   (table_value_i),
    .column_i        (column_i),
    .scan_row_i      (scan_row_i),
    .red_top_i       (red_top_i),
    .green_top_i     (green_top_i),
    .blue_top_i      (blue_top_i),
    .red_bottom_i    (red_bottom_i),
    .green_bottom_i  (green_bottom_i),
    .blue_bottom_i   (blue_bottom_i),
    .take_i          (take),
    .lk_o            (lk)
  );

  gbe_emit #(
    .PLANES (PLANES)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lk_i         (lk),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_bank_o   (out_bank_o),
    .out_row_o    (out_row_o),
    .out_plane_o  (out_plane_o),
    .out_column_o (out_column_o),
    .plane_byte_o (plane_byte_o),
    .last_plane_o (last_plane_o)
  );

endmodule

@@ sim/gamma_bitplane_encoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_bitplane_encoder_unit_test
// Loads the red, green and blue gamma tables and sends pixel pairs. The plane
// bytes, addresses, bank and last flag of every output beat are checked in
// order against a predictor with its own copy of the tables and frame bank.
// ----------------------------------------------------------------------------
module gamma_bitplane_encoder_unit_test;
  import gbe_pkg::*;

  localparam int unsigned Planes      = PlanesDef;
  localparam int unsigned ColumnCount = ColumnCountDef;
  localparam int unsigned ScanRows    = ScanRowsDef;
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [ChanW-1:0] ChanNone = 2'd3;

  typedef struct packed {
    logic                                req;
    logic [ChanW-1:0]                    chan;
    logic [SampleW-1:0]                  idx;
    logic [SampleW-1:0]                  val;
    logic [ColW-1:0]                     col;
    logic [RowW-1:0]                     row;
    logic [SampleCount-1:0][SampleW-1:0] smp;  // rt, gt, bt, rb, gb, bb from index 0
  } pixel_req_t;

  typedef struct packed {
    logic                   bank;
    logic [RowW-1:0]        row;
    logic [PlaneOutW-1:0]   plane;
    logic [ColW-1:0]        col;
    logic [SampleCount-1:0] bits;
    logic                   last;
  } plane_beat_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   req_type;
  logic [ChanW-1:0]       table_channel;
  logic [SampleW-1:0]     table_index;
  logic [SampleW-1:0]     table_value;
  logic [ColW-1:0]        column;
  logic [RowW-1:0]        scan_row;
  logic [SampleW-1:0]     red_top, green_top, blue_top;
  logic [SampleW-1:0]     red_bottom, green_bottom, blue_bottom;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_bank;
  logic [RowW-1:0]        out_row;
  logic [PlaneOutW-1:0]   out_plane;
  logic [ColW-1:0]        out_column;
  logic [SampleCount-1:0] plane_byte;
  logic                   last_plane;

  // predictor state
  logic [SampleW-1:0] gamma_lut [3][TableDepth];
  bit                 lut_loaded [3][TableDepth];
  logic               frame_bank;
  plane_beat_t        plane_q [$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned stall_left;

  gamma_bitplane_encoder_unit #(
    .PLANES      (Planes),
    .COLUMN_COUNT(ColumnCount),
    .SCAN_ROWS   (ScanRows)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .table_channel_i(table_channel),
    .table_index_i  (table_index),
    .table_value_i  (table_value),
    .column_i       (column),
    .scan_row_i     (scan_row),
    .red_top_i      (red_top),
    .green_top_i    (green_top),
    .blue_top_i     (blue_top),
    .red_bottom_i   (red_bottom),
    .green_bottom_i (green_bottom),
    .blue_bottom_i  (blue_bottom),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .out_bank_o     (out_bank),
    .out_row_o      (out_row),
    .out_plane_o    (out_plane),
    .out_column_o   (out_column),
    .plane_byte_o   (plane_byte),
    .last_plane_o   (last_plane)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("gamma_bitplane_encoder_unit_test: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  task automatic store_gamma(input pixel_req_t b);
    // the unused channel code drops the write
    if (b.chan != ChanNone) begin
      gamma_lut[b.chan][b.idx]  = b.val;
      lut_loaded[b.chan][b.idx] = 1'b1;
    end
  endtask

  task automatic predict_planes(input pixel_req_t b);
    logic [SampleW-1:0] mapped [SampleCount];
    plane_beat_t        e;
    int unsigned        pos;
    for (int k = 0; k < SampleCount; k++) mapped[k] = gamma_lut[k % 3][b.smp[k]];
    for (int p = 0; p < Planes; p++) begin
      pos    = SampleW - Planes + p;
      e.bank = frame_bank;
      e.row  = b.row;
      e.plane = p[PlaneOutW-1:0];
      e.col  = b.col;
      for (int k = 0; k < SampleCount; k++) e.bits[k] = mapped[k][pos];
      e.last = (p == Planes - 1);
      plane_q.push_back(e);
    end
    if (b.col == ColumnCount - 1 && b.row == ScanRows - 1) frame_bank = ~frame_bank;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall and in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int unsigned r;
    plane_beat_t want, got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_bank, out_row, out_plane, out_column, plane_byte, last_plane};
      if (plane_q.size() == 0) begin
        $display("%0t: plane beat with none pending: bank %0d row %0d plane %0d col %0d byte %02h last %0d",
                 $time, got.bank, got.row, got.plane, got.col, got.bits, got.last);
        mismatches++;
      end else begin
        want = plane_q.pop_front();
        if (got !== want) begin
          $display("%0t: expected bank %0d row %0d plane %0d col %0d byte %02h last %0d",
                   $time, want.bank, want.row, want.plane, want.col, want.bits, want.last);
          $display("%0t: actual   bank %0d row %0d plane %0d col %0d byte %02h last %0d",
                   $time, got.bank, got.row, got.plane, got.col, got.bits, got.last);
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 30);
      end else if (r < 90) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(6, 24);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_beat(input pixel_req_t b);
    in_valid      <= 1'b1;
    req_type      <= b.req;
    table_channel <= b.chan;
    table_index   <= b.idx;
    table_value   <= b.val;
    column        <= b.col;
    scan_row      <= b.row;
    red_top       <= b.smp[0];
    green_top     <= b.smp[1];
    blue_top      <= b.smp[2];
    red_bottom    <= b.smp[3];
    green_bottom  <= b.smp[4];
    blue_bottom   <= b.smp[5];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.req == ReqPixel) predict_planes(b);
    else store_gamma(b);
  endtask

  task automatic idle(input int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // the fields a beat's kind ignores carry noise
  function automatic pixel_req_t noise_beat();
    pixel_req_t b;
    b.req  = ReqGamma;
    b.chan = $urandom_range(0, 3);
    b.idx  = $urandom_range(0, 255);
    b.val  = $urandom_range(0, 255);
    b.col  = $urandom_range(0, ColumnCount - 1);
    b.row  = $urandom_range(0, ScanRows - 1);
    for (int k = 0; k < SampleCount; k++) b.smp[k] = $urandom_range(0, 255);
    return b;
  endfunction

  function automatic pixel_req_t gamma_beat(input logic [ChanW-1:0] chan,
                                            input logic [SampleW-1:0] idx,
                                            input logic [SampleW-1:0] val);
    pixel_req_t b = noise_beat();
    b.req  = ReqGamma;
    b.chan = chan;
    b.idx  = idx;
    b.val  = val;
    return b;
  endfunction

  function automatic pixel_req_t pixel_beat(input logic [ColW-1:0] col,
                                            input logic [RowW-1:0] row,
                                            input logic [SampleW-1:0] rt, gt, bt,
                                            input logic [SampleW-1:0] rb, gb, bb);
    pixel_req_t b = noise_beat();
    b.req = ReqPixel;
    b.col = col;
    b.row = row;
    b.smp = {bb, gb, rb, bt, gt, rt};
    return b;
  endfunction

  // random sample whose gamma entry has been loaded
  function automatic logic [SampleW-1:0] loaded_sample(input int unsigned ch);
    int unsigned i = $urandom_range(0, TableDepth - 1);
    while (!lut_loaded[ch][i]) i = (i + 1) % TableDepth;
    return i[SampleW-1:0];
  endfunction

  function automatic pixel_req_t random_pixel(input logic [ColW-1:0] col,
                                              input logic [RowW-1:0] row);
    pixel_req_t b = noise_beat();
    b.req = ReqPixel;
    b.col = col;
    b.row = row;
    for (int k = 0; k < SampleCount; k++) b.smp[k] = loaded_sample(k % 3);
    return b;
  endfunction

  function automatic pixel_req_t random_beat();
    int unsigned r = $urandom_range(0, 99);
    if (r < 35) return gamma_beat(r < 5 ? ChanNone : $urandom_range(0, 2),
                                  $urandom_range(0, 255), $urandom_range(0, 255));
    if (r < 50) return random_pixel(ColumnCount - 1, ScanRows - 1);
    return random_pixel($urandom_range(0, ColumnCount - 1), $urandom_range(0, ScanRows - 1));
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (plane_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_table_extremes();
    send_beat(gamma_beat(ChanRed,   8'h00, 8'h00));
    send_beat(gamma_beat(ChanGreen, 8'h00, 8'h00));
    send_beat(gamma_beat(ChanBlue,  8'h00, 8'h00));
    send_beat(gamma_beat(ChanRed,   8'hFF, 8'hFF));
    send_beat(gamma_beat(ChanGreen, 8'hFF, 8'hFF));
    send_beat(gamma_beat(ChanBlue,  8'hFF, 8'hFF));
    send_beat(pixel_beat(0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_beat(pixel_beat(5, 9, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // distinct patterns per channel expose swapped bits and planes
  task automatic test_bit_positions();
    send_beat(gamma_beat(ChanRed,   8'h55, 8'hA5));
    send_beat(gamma_beat(ChanGreen, 8'hAA, 8'h3C));
    send_beat(gamma_beat(ChanBlue,  8'h0F, 8'h81));
    send_beat(pixel_beat(21, 6, 8'h55, 8'hAA, 8'h0F, 8'h00, 8'hFF, 8'h00));
    send_beat(pixel_beat(42, 3, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F));
  endtask

  task automatic test_ignored_channel();
    send_beat(gamma_beat(ChanNone, 8'h00, 8'hFF));
    send_beat(gamma_beat(ChanNone, 8'h33, 8'h77));
    send_beat(pixel_beat(1, 1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_table_rewrite();
    send_beat(gamma_beat(ChanRed, 8'hFF, 8'h5A));
    send_beat(pixel_beat(7, 2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  task automatic test_bank_toggle();
    send_beat(pixel_beat(ColumnCount - 1, ScanRows - 1,
                         8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00));
    send_beat(pixel_beat(0, 0, 8'h55, 8'hAA, 8'h0F, 8'h55, 8'hAA, 8'h0F));
    send_beat(pixel_beat(ColumnCount - 1, ScanRows - 2,
                         8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
    send_beat(pixel_beat(ColumnCount - 2, ScanRows - 1,
                         8'h55, 8'h00, 8'h0F, 8'hFF, 8'hAA, 8'h00));
    send_beat(pixel_beat(ColumnCount - 1, ScanRows - 1,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) begin
      send_beat(random_beat());
      idle(pick_gap());
    end
  endtask

  task automatic test_drained_restart();
    wait_drained();
    repeat (10) send_beat(random_beat());
  endtask

  task automatic test_streaming(input int unsigned count);
    repeat (count) send_beat(random_beat());
  endtask

  // ordered tail of a frame: last scan row swept to its final column
  task automatic test_frame_tail(input int unsigned sweeps);
    repeat (sweeps) begin
      for (int c = ColumnCount - 6; c < ColumnCount; c++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(gamma_beat($urandom_range(0, 2), $urandom_range(0, 255),
                               $urandom_range(0, 255)));
        send_beat(random_pixel(c, ScanRows - 1));
        idle(pick_gap());
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    req_type      <= ReqGamma;
    table_channel <= ChanRed;
    table_index   <= '0;
    table_value   <= '0;
    column        <= '0;
    scan_row      <= '0;
    red_top       <= '0;
    green_top     <= '0;
    blue_top      <= '0;
    red_bottom    <= '0;
    green_bottom  <= '0;
    blue_bottom   <= '0;
    out_stall     <= 1'b0;
    stall_left    = 0;
    mismatches    = 0;
    cycle_count   = 0;
    frame_bank    = 1'b0;
    foreach (lut_loaded[c, i]) lut_loaded[c][i] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_extremes();
    test_bit_positions();
    test_ignored_channel();
    test_table_rewrite();
    test_bank_toggle();
    test_random_traffic(140);
    test_drained_restart();
    test_streaming(50);
    test_frame_tail(6);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("gamma_bitplane_encoder_unit_test: clean");
    end else begin
      $display("gamma_bitplane_encoder_unit_test: errors");
    end
    $finish;
  end

endmodule
